### rtl/whs_pkg.sv
// ============================================================================
// Waypoint heading steer package
// Types, widths, register indexes, reset values and the CORDIC angle table
// shared by the steering controller and its iterative CORDIC unit.
// ============================================================================
package whs_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int DEADBAND_DEF     = 182;
   localparam int CORDIC_STEPS_MAX = 24;

   localparam int COORD_W     = 16;
   localparam int DIFF_W      = 17;
   localparam int DIST_W      = 18;
   localparam int ANGLE_W     = 16;
   localparam int MAG_W       = 17;
   localparam int TIME_W      = 25;
   localparam int LIFE_W      = 24;
   localparam int ACC_W       = 32;
   localparam int CORDIC_FRAC = 8;
   localparam int CORDIC_W    = 28;
   localparam int ATAN_IDX_W  = 5;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 24;

   localparam logic [COORD_W-1:0] ARRIVE_RADIUS_RST  = 16'd16;
   localparam logic [LIFE_W-1:0]  LIFETIME_START_RST = 24'd65535;
   localparam logic [TIME_W-1:0]  TIME_LEFT_RST      = 25'd65535;

   localparam logic [ACC_W-1:0] ACC_HALF_TURN = 32'h8000_0000;
   localparam logic [ACC_W-1:0] ACC_ROUND     = 32'h0000_8000;

   localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAYPOINT_X     = 4'd0,
      CSR_WAYPOINT_Y     = 4'd1,
      CSR_ARRIVE_RADIUS  = 4'd2,
      CSR_LIFETIME_START = 4'd3
   } whs_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_CHECK = 3'd1,
      ST_SPIN  = 3'd2,
      ST_EVAL  = 3'd3,
      ST_OUT   = 3'd4
   } whs_state_type;

   typedef struct packed {
      logic                       start_req;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic [ANGLE_W-1:0]         heading;
      logic [COORD_W-1:0]         elapsed;
   } whs_req_type;

   typedef struct packed {
      logic move_forward;
      logic turn_left;
      logic turn_right;
      logic done_res;
   } whs_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIFF_W-1:0] dx;
      logic [DIFF_W-1:0] dy;
   } whs_cordic_req_type;

   typedef struct packed {
      logic               done;
      logic [ANGLE_W-1:0] bearing;
   } whs_cordic_rsp_type;

endpackage

### rtl/waypoint_heading_steer.sv
// ============================================================================
// Waypoint heading steer
// Bang-bang heading controller that steers toward a configured waypoint,
// with a lifetime budget and Manhattan-distance arrival check.
// ============================================================================
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid/req_ready    one tick item (whs_req_type)
//   rsp_      out        rsp_valid/rsp_ready    drive flags and done (whs_rsp_type)
//   csr_      in         csr_valid/csr_ready    register index and write data
//
// A tick that runs the bearing passes CHECK, SPIN, EVAL and OUT, and waits in SPIN
// for the CORDIC unit, which resolves one angle step per cycle. A tick that is
// already done or times out goes from CHECK straight to OUT. Reset is synchronous
// and returns the state, settings and status registers to their documented values.
// A result waits in the output register; a new item can be taken meanwhile,
// and the sequencer holds its next result until that register is free.
//
module waypoint_heading_steer #(
   parameter int CordicSteps = whs_pkg::CORDIC_STEPS_DEF,
   parameter int Deadband    = whs_pkg::DEADBAND_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  whs_pkg::whs_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output whs_pkg::whs_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [whs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [whs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import whs_pkg::*;

   whs_state_type state_ff, state_in;

   logic [COORD_W-1:0] waypoint_x_ff, waypoint_x_in;
   logic [COORD_W-1:0] waypoint_y_ff, waypoint_y_in;
   logic [COORD_W-1:0] arrive_radius_ff, arrive_radius_in;
   logic [LIFE_W-1:0]  lifetime_start_ff, lifetime_start_in;

   logic [TIME_W-1:0]  time_left_ff, time_left_in;
   logic               finished_ff, finished_in;
   logic               move_ff, move_in;
   logic               left_ff, left_in;
   logic               right_ff, right_in;

   logic               start_ff, start_in;
   logic               fin_work_ff, fin_work_in;
   logic [TIME_W-1:0]  tl_work_ff, tl_work_in;
   logic [DIFF_W-1:0]  dx_ff, dx_in;
   logic [DIFF_W-1:0]  dy_ff, dy_in;
   logic [ANGLE_W-1:0] heading_ff, heading_in;
   logic               arrive_ff, arrive_in;
   logic [ANGLE_W-1:0] err_ff, err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   whs_rsp_type        rsp_data_ff, rsp_data_in;

   logic               accept_c, commit_c, spin_go_c, err_load_c, eval_c, rsp_load_c;
   logic [TIME_W-1:0]  tl_base_c;
   logic [DIFF_W-1:0]  dx_abs_c, dy_abs_c;
   logic [DIST_W-1:0]  dist_c;
   logic [MAG_W-1:0]   mag_c;
   logic               outside_c;

   whs_cordic_req_type cordic_req;
   whs_cordic_rsp_type cordic_rsp;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fin_work_ff || tl_work_ff[TIME_W-1]) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_SPIN;
            end
         end
         ST_SPIN: begin
            if (cordic_rsp.done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: strobes.
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      accept_c   = req_valid && (state_ff == ST_IDLE);
      commit_c   = (state_ff == ST_CHECK) && !fin_work_ff;
      spin_go_c  = commit_c && !tl_work_ff[TIME_W-1];
      err_load_c = (state_ff == ST_SPIN) && cordic_rsp.done;
      eval_c     = (state_ff == ST_EVAL);
      rsp_load_c = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      waypoint_x_in     = waypoint_x_ff;
      waypoint_y_in     = waypoint_y_ff;
      arrive_radius_in  = arrive_radius_ff;
      lifetime_start_in = lifetime_start_ff;
      if (csr_valid) begin
         unique case (whs_csr_type'(csr_index))
            CSR_WAYPOINT_X:     waypoint_x_in     = csr_data[COORD_W-1:0];
            CSR_WAYPOINT_Y:     waypoint_y_in     = csr_data[COORD_W-1:0];
            CSR_ARRIVE_RADIUS:  arrive_radius_in  = csr_data[COORD_W-1:0];
            CSR_LIFETIME_START: lifetime_start_in = csr_data[LIFE_W-1:0];
            default: begin
               waypoint_x_in = waypoint_x_ff;
            end
         endcase
      end
   end

   // Datapath.
   always_comb begin
      tl_base_c = req_data.start_req ? {1'b0, lifetime_start_ff} : time_left_ff;
      dx_abs_c  = dx_ff[DIFF_W-1] ? (DIFF_W'(0) - dx_ff) : dx_ff;
      dy_abs_c  = dy_ff[DIFF_W-1] ? (DIFF_W'(0) - dy_ff) : dy_ff;
      dist_c    = DIST_W'(dx_abs_c) + DIST_W'(dy_abs_c);
      mag_c     = err_ff[ANGLE_W-1] ? (MAG_W'(0) - {1'b1, err_ff}) : {1'b0, err_ff};
      outside_c = (mag_c > MAG_W'(Deadband));

      start_in    = start_ff;
      fin_work_in = fin_work_ff;
      tl_work_in  = tl_work_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      heading_in  = heading_ff;
      arrive_in   = arrive_ff;
      err_in      = err_ff;

      time_left_in = time_left_ff;
      finished_in  = finished_ff;
      move_in      = move_ff;
      left_in      = left_ff;
      right_in     = right_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (accept_c) begin
         start_in    = req_data.start_req;
         fin_work_in = req_data.start_req ? 1'b0 : finished_ff;
         tl_work_in  = tl_base_c - TIME_W'(req_data.elapsed);
         dx_in       = {waypoint_x_ff[COORD_W-1], waypoint_x_ff}
                       - {req_data.pos_x[COORD_W-1], req_data.pos_x};
         dy_in       = {waypoint_y_ff[COORD_W-1], waypoint_y_ff}
                       - {req_data.pos_y[COORD_W-1], req_data.pos_y};
         heading_in  = req_data.heading;
      end

      if (commit_c) begin
         time_left_in = tl_work_ff;
         finished_in  = tl_work_ff[TIME_W-1];
         arrive_in    = (dist_c < DIST_W'(arrive_radius_ff));
      end

      if (err_load_c) begin
         err_in = cordic_rsp.bearing - heading_ff;
      end

      if (eval_c) begin
         move_in  = !arrive_ff;
         left_in  = outside_c && err_ff[ANGLE_W-1];
         right_in = outside_c && !err_ff[ANGLE_W-1];
         if (arrive_ff) begin
            finished_in = 1'b1;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load_c) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.move_forward = move_ff;
         rsp_data_in.turn_left    = left_ff;
         rsp_data_in.turn_right   = right_ff;
         rsp_data_in.done_res     = finished_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         waypoint_x_ff     <= '0;
         waypoint_y_ff     <= '0;
         arrive_radius_ff  <= ARRIVE_RADIUS_RST;
         lifetime_start_ff <= LIFETIME_START_RST;
         time_left_ff      <= TIME_LEFT_RST;
         finished_ff       <= 1'b0;
         move_ff           <= 1'b0;
         left_ff           <= 1'b0;
         right_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         waypoint_x_ff     <= waypoint_x_in;
         waypoint_y_ff     <= waypoint_y_in;
         arrive_radius_ff  <= arrive_radius_in;
         lifetime_start_ff <= lifetime_start_in;
         time_left_ff      <= time_left_in;
         finished_ff       <= finished_in;
         move_ff           <= move_in;
         left_ff           <= left_in;
         right_ff          <= right_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      fin_work_ff <= fin_work_in;
      tl_work_ff  <= tl_work_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      heading_ff  <= heading_in;
      arrive_ff   <= arrive_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign cordic_req.start = spin_go_c;
   assign cordic_req.dx    = dx_ff;
   assign cordic_req.dy    = dy_ff;

   whs_cordic #(
      .CordicSteps (CordicSteps)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .cordic_req (cordic_req),
      .cordic_rsp (cordic_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The turn commands are never given together.
   a_turn_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.turn_left && rsp_data_ff.turn_right))
      else $error("both turn flags set in a result");

   // The CORDIC reports only while the sequencer waits for it.
   a_cordic_done_in_spin: assert property (@(posedge clock) disable iff (reset)
      cordic_rsp.done |-> (state_ff == ST_SPIN))
      else $error("CORDIC done outside the wait state");

   // A result is loaded only from the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

   // Done is cleared only by an item that restarts the action.
   a_done_cleared_by_start: assert property (@(posedge clock) disable iff (reset)
      ($fell(finished_ff) && !$past(reset)) |-> $past(start_ff))
      else $error("done cleared without a start request");

endmodule

### rtl/whs_cordic.sv
// ============================================================================
// Waypoint heading steer iterative CORDIC
// Vectoring CORDIC atan2 that resolves one angle step per cycle with a single
// shift-and-add unit, and returns the bearing rounded to a 16-bit angle.
// ============================================================================
module whs_cordic #(
   parameter int CordicSteps = whs_pkg::CORDIC_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  whs_pkg::whs_cordic_req_type cordic_req,
   output whs_pkg::whs_cordic_rsp_type cordic_rsp
);
   import whs_pkg::*;

   localparam int IterW = $clog2(CordicSteps);
   localparam logic [IterW-1:0] LastIter = IterW'(CordicSteps - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [IterW-1:0]           cnt_ff, cnt_in;
   logic                       zero_ff, zero_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic [ACC_W-1:0]           z_ff, z_in;

   logic signed [CORDIC_W-1:0] x_init, y_init, xs, ys;
   logic [ACC_W-1:0]           atan_c, z_round;
   logic                       last_c;

   always_comb begin
      x_init = {{(CORDIC_W-DIFF_W-CORDIC_FRAC){cordic_req.dx[DIFF_W-1]}},
                cordic_req.dx, {CORDIC_FRAC{1'b0}}};
      y_init = {{(CORDIC_W-DIFF_W-CORDIC_FRAC){cordic_req.dy[DIFF_W-1]}},
                cordic_req.dy, {CORDIC_FRAC{1'b0}}};
      xs     = x_ff >>> cnt_ff;
      ys     = y_ff >>> cnt_ff;
      atan_c = ATAN_TURNS[ATAN_IDX_W'(cnt_ff)];
      last_c = (cnt_ff == LastIter);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;

      if (cordic_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         zero_in = (cordic_req.dx == '0) && (cordic_req.dy == '0);
         if (cordic_req.dx[DIFF_W-1]) begin
            x_in = -x_init;
            y_in = -y_init;
            z_in = ACC_HALF_TURN;
         end else begin
            x_in = x_init;
            y_in = y_init;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (!y_ff[CORDIC_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_c;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_c;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last_c) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign z_round            = z_ff + ACC_ROUND;
   assign cordic_rsp.done    = done_ff;
   assign cordic_rsp.bearing = zero_ff ? '0 : z_round[ACC_W-1:ACC_W-ANGLE_W];

endmodule

### tb/sv/tb_waypoint_heading_steer.sv
// ============================================================================
// Waypoint heading steer testbench
// Sends control ticks and register writes to the steering controller. It
// predicts the drive flags and the done bit of every tick, using its own
// bit-exact CORDIC bearing, and checks the results in order. Both channels
// stall at random. Register settings change only while the block is idle.
// ============================================================================
module tb_waypoint_heading_steer;
   timeunit 1ns;
   timeprecision 1ps;

   import whs_pkg::*;

   localparam int BEARING_STEPS   = (CORDIC_STEPS_DEF < CORDIC_STEPS_MAX) ?
                                    CORDIC_STEPS_DEF : CORDIC_STEPS_MAX;
   localparam int PHASES          = 8;
   localparam int TICKS_PER_PHASE = 100;
   localparam int TAIL_CYCLES     = 3 * (CORDIC_STEPS_DEF + 5);
   localparam int MAX_PRINTED     = 100;
   localparam int WATCHDOG_NS     = 1000000;
   localparam int CSR_COUNT       = int'(CSR_LIFETIME_START) + 1;
   localparam int COORD_HI        = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_LO        = -(1 << (COORD_W - 1));

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP = '1;

   class steer_scoreboard;
      logic signed [COORD_W-1:0] wp_x;
      logic signed [COORD_W-1:0] wp_y;
      logic [COORD_W-1:0]        radius;
      logic [LIFE_W-1:0]         life_start;
      int                        time_left;
      bit                        finished;
      bit                        move_f;
      bit                        left_f;
      bit                        right_f;
      whs_rsp_type               drive_q[$];
      int                        errors;

      function new();
         wp_x       = '0;
         wp_y       = '0;
         radius     = ARRIVE_RADIUS_RST;
         life_start = LIFETIME_START_RST;
         time_left  = int'(TIME_LEFT_RST);
         finished   = 1'b0;
         move_f     = 1'b0;
         left_f     = 1'b0;
         right_f    = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WAYPOINT_X:     wp_x = value[COORD_W-1:0];
            CSR_WAYPOINT_Y:     wp_y = value[COORD_W-1:0];
            CSR_ARRIVE_RADIUS:  radius = value[COORD_W-1:0];
            CSR_LIFETIME_START: life_start = value[LIFE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [ANGLE_W-1:0] bearing_of(int dx, int dy);
         longint           x;
         longint           y;
         longint           xs;
         longint           ys;
         logic [ACC_W-1:0] z;
         if (dx == 0 && dy == 0) begin
            return '0;
         end
         x = longint'(dx) * (longint'(1) << CORDIC_FRAC);
         y = longint'(dy) * (longint'(1) << CORDIC_FRAC);
         z = '0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = ACC_HALF_TURN;
         end
         for (int i = 0; i < BEARING_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_TURNS[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_TURNS[i];
            end
         end
         z = z + ACC_ROUND;
         return z[ACC_W-1:ACC_W-ANGLE_W];
      endfunction

      // Returns whether the tick was acted on rather than held by a finished action.
      function bit take_tick(whs_req_type t);
         int                 dx;
         int                 dy;
         int                 manhattan;
         int                 err;
         logic [ANGLE_W-1:0] err_u;
         bit                 active;
         whs_rsp_type        want;
         if (t.start_req) begin
            time_left = int'(life_start);
            finished  = 1'b0;
         end
         active = !finished;
         if (active) begin
            time_left = time_left - int'(t.elapsed);
            if (time_left < 0) begin
               finished = 1'b1;
            end else begin
               dx        = int'(wp_x) - int'($signed(t.pos_x));
               dy        = int'(wp_y) - int'($signed(t.pos_y));
               manhattan = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
               if (manhattan < int'(radius)) begin
                  finished = 1'b1;
                  move_f   = 1'b0;
               end else begin
                  move_f = 1'b1;
               end
               err_u   = bearing_of(dx, dy) - t.heading;
               err     = int'($signed(err_u));
               left_f  = 1'b0;
               right_f = 1'b0;
               if ((err < 0 ? -err : err) > DEADBAND_DEF) begin
                  if (err < 0) begin
                     left_f = 1'b1;
                  end else begin
                     right_f = 1'b1;
                  end
               end
            end
         end
         want.move_forward = move_f;
         want.turn_left    = left_f;
         want.turn_right   = right_f;
         want.done_res     = finished;
         drive_q.push_back(want);
         return active;
      endfunction

      task report_mismatch(string what);
         if (errors < MAX_PRINTED) begin
            $display("%0t ns: %s", $time, what);
         end
         errors++;
      endtask

      task check_drive(whs_rsp_type got);
         whs_rsp_type want;
         if (drive_q.size() == 0) begin
            report_mismatch($sformatf("result %b arrived with nothing expected", got));
            return;
         end
         want = drive_q.pop_front();
         if (got !== want) begin
            report_mismatch($sformatf(
               "move %b/%b left %b/%b right %b/%b done %b/%b (got/expected)",
               got.move_forward, want.move_forward, got.turn_left, want.turn_left,
               got.turn_right, want.turn_right, got.done_res, want.done_res));
         end
      endtask

      function int pending();
         return drive_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   whs_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   whs_rsp_type            rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   steer_scoreboard sb;
   bit              idle_on;
   int              active_ticks;

   waypoint_heading_steer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("tb_waypoint_heading_steer failed");
      $finish;
   end

   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_drive(rsp_data);
      end
   end

   function automatic int clamp16(int v);
      if (v > COORD_HI) begin
         return COORD_HI;
      end
      if (v < COORD_LO) begin
         return COORD_LO;
      end
      return v;
   endfunction

   task automatic send_tick(input whs_req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (sb.take_tick(item)) begin
         active_ticks++;
      end
   endtask

   task automatic send_fields(input bit st, input int px, input int py, input int hd,
                              input int el);
      whs_req_type item;
      item.start_req = st;
      item.pos_x     = 16'(px);
      item.pos_y     = 16'(py);
      item.heading   = 16'(hd);
      item.elapsed   = 16'(el);
      send_tick(item);
   endtask

   task automatic send_noise();
      whs_req_type item;
      item.start_req = 1'($urandom);
      item.pos_x     = 16'($urandom);
      item.pos_y     = 16'($urandom);
      item.heading   = 16'($urandom);
      item.elapsed   = 16'($urandom);
      send_tick(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_regs(input logic [COORD_W-1:0] wx, input logic [COORD_W-1:0] wy,
                             input logic [COORD_W-1:0] rad, input logic [LIFE_W-1:0] life,
                             input bit stray);
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  value;
      int                     first;
      first = $urandom_range(0, CSR_COUNT - 1);
      for (int k = 0; k <= CSR_COUNT; k++) begin
         if (k == CSR_COUNT) begin
            if (!stray) begin
               break;
            end
            idx   = CSR_INDEX_W'($urandom_range(CSR_COUNT, int'(CSR_INDEX_TOP)));
            value = (CSR_DATA_W)'($urandom);
         end else begin
            idx = CSR_INDEX_W'((first + k) % CSR_COUNT);
            case (idx)
               CSR_WAYPOINT_X:    value = {(CSR_DATA_W - COORD_W)'($urandom), wx};
               CSR_WAYPOINT_Y:    value = {(CSR_DATA_W - COORD_W)'($urandom), wy};
               CSR_ARRIVE_RADIUS: value = {(CSR_DATA_W - COORD_W)'($urandom), rad};
               default:           value = life;
            endcase
         end
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx, value);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_trip();
      whs_req_type        item;
      int                 px;
      int                 py;
      int                 wx;
      int                 wy;
      int                 dx;
      int                 dy;
      int                 len;
      int                 lim;
      int                 mode;
      logic [ANGLE_W-1:0] aim;
      wx = int'(sb.wp_x);
      wy = int'(sb.wp_y);
      if ($urandom_range(0, 1) == 0) begin
         px = clamp16(wx + int'($urandom_range(0, 1200)) - 600);
         py = clamp16(wy + int'($urandom_range(0, 1200)) - 600);
      end else begin
         px = int'($urandom_range(0, 65535)) + COORD_LO;
         py = int'($urandom_range(0, 65535)) + COORD_LO;
      end
      len  = $urandom_range(1, 40);
      mode = $urandom_range(0, 2);
      lim  = int'(sb.life_start) / 12;
      if (lim > 65535) begin
         lim = 65535;
      end
      if (lim < 1) begin
         lim = 1;
      end
      for (int n = 0; n < len; n++) begin
         dx  = wx - px;
         dy  = wy - py;
         aim = sb.bearing_of(dx, dy);
         item.start_req = (n == 0) || ($urandom_range(0, 39) == 0);
         item.pos_x     = 16'(px);
         item.pos_y     = 16'(py);
         case (mode)
            0: item.heading = aim + 16'(int'($urandom_range(0, 2 * DEADBAND_DEF + 4))
                                       - DEADBAND_DEF - 2);
            1: item.heading = aim + 16'(int'($urandom_range(0, 8000)) - 4000);
            default: item.heading = 16'($urandom);
         endcase
         item.elapsed = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, lim));
         send_tick(item);
         if (sb.finished) begin
            if ($urandom_range(0, 2) == 0) begin
               item.start_req = 1'b0;
               item.elapsed   = 16'($urandom);
               send_tick(item);
            end
            break;
         end
         px = clamp16(px + dx * int'($urandom_range(0, 6)) / 8
                      + int'($urandom_range(0, 6)) - 3);
         py = clamp16(py + dy * int'($urandom_range(0, 6)) / 8
                      + int'($urandom_range(0, 6)) - 3);
      end
   endtask

   initial begin
      int                 offs[5];
      int                 goal;
      logic [ANGLE_W-1:0] aim;
      sb           = new();
      idle_on      = 1'b0;
      active_ticks = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      send_fields(1'b1, 0, 0, 0, 0);
      send_fields(1'b0, 100, 100, 16'h1234, 5);
      send_fields(1'b1, COORD_LO, COORD_LO, 0, 0);
      send_fields(1'b0, COORD_HI, COORD_HI, 16'hFFFF, 0);
      send_fields(1'b0, COORD_HI, COORD_LO, 16'h8000, 1);
      send_fields(1'b0, COORD_LO, COORD_HI, 16'h7FFF, 1);
      aim  = sb.bearing_of(1000, 0);
      offs = '{-DEADBAND_DEF - 1, -DEADBAND_DEF, 0, DEADBAND_DEF, DEADBAND_DEF + 1};
      foreach (offs[k]) begin
         send_fields(1'b0, -1000, 0, int'(aim) - offs[k], 0);
      end
      send_fields(1'b1, -500, -500, 0, 65535);
      send_fields(1'b0, -500, 400, 0, 1);
      send_fields(1'b0, 0, 0, 0, 0);
      drain();
      write_regs('0, '0, '0, '0, 1'b1);
      send_fields(1'b1, 0, 0, 16'h4000, 0);
      send_fields(1'b0, 1, 0, 0, 0);
      send_fields(1'b0, 0, 0, 0, 1);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         case (p)
            0: write_regs(16'(COORD_HI), 16'(COORD_LO), '1, '1, 1'b1);
            1: write_regs(16'(COORD_LO), 16'(COORD_HI), '0, '0, 1'b0);
            default: write_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 3000)),
                                24'($urandom_range(200, 300000)), 1'($urandom));
         endcase
         goal = active_ticks + TICKS_PER_PHASE;
         while (active_ticks < goal) begin
            if (p != PHASES - 1 && $urandom_range(0, 7) == 0) begin
               idle_on = !idle_on;
            end
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 5)) send_noise();
            end else begin
               run_trip();
            end
            if ($urandom_range(0, 59) == 0) begin
               drain();
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_waypoint_heading_steer passed");
      end else begin
         $display("tb_waypoint_heading_steer failed");
      end
      $finish;
   end

endmodule
